>>> src/lfu_pkg.sv
`default_nettype none
package lfu_pkg;
   localparam int MAX_ENTRIES = 64;
   localparam int TAG_BITS    = 64;
   localparam int VALUE_BITS  = 64;
   localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CH_W   = IDX_W + 2;
   localparam int CFG_W  = 7;
   localparam int CAP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   typedef struct packed {
      logic [31:0]           stamp;
      logic [31:0]           count;
      logic [VALUE_BITS-1:0] value;
      logic [TAG_BITS-1:0]   tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // strict heap order: count first, stamp breaks ties
   function automatic logic ranks_below(input entry_type a, input entry_type b);
      if (a.count != b.count) return a.count < b.count;
      return a.stamp < b.stamp;
   endfunction
endpackage
`default_nettype wire

>>> src/lfu_cache_heap_top.sv
`default_nettype none
// LFU cache, min-heap in one single-port-read RAM, driven by a small sequencer.
// Sequence: tag scan that reads then compares each entry (stops at the hit),
// then a sink walk (read left child, read right child, pick and move, per
// level) or a swim walk (read parent, compare and move, per level), then the
// result is held until taken. Throughput: one transaction at a time.
// Reset (synchronous, high): entry count and stamp cleared, capacity 64;
// heap RAM contents are not cleared and are never read before being written.
module lfu_cache_heap_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,  // key_tag[63:0], write_value[127:64]
   input  wire logic [0:0]   req_tuser,  // func (0 lookup, 1 insert)
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // hit[0], read_value[64:1], evicted[65], evicted_tag[129:66], zero pad
   output logic [135:0]      rsp_tdata,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [6:0]   csr_data   // capacity_in_use
);
   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001,
      S_RD   = 10'b0000000010,  // issue scan read
      S_CMP  = 10'b0000000100,  // tag compare
      S_SK   = 10'b0000001000,  // sink: read left child
      S_SKL  = 10'b0000010000,  // sink: left data, read right
      S_SKR  = 10'b0000100000,  // sink: right data
      S_SKD  = 10'b0001000000,  // sink: pick and move
      S_SW   = 10'b0010000000,  // swim: read parent
      S_SWP  = 10'b0100000000,  // swim: compare and move
      S_OUT  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [lfu_pkg::CAP_W-1:0]   cap_ff, cap_in, cap_eff;
   logic [lfu_pkg::CNT_W-1:0]   total_ff, total_in, idx_ff, idx_in;
   logic [lfu_pkg::IDX_W-1:0]   pos_ff, pos_in;
   logic [31:0]                 stamp_ff, stamp_in;
   lfu_pkg::entry_type          cur_ff, cur_in, left_ff, left_in, right_ff, right_in;
   logic                        rvld_ff, rvld_in;
   logic [lfu_pkg::TAG_BITS-1:0]   key_ff, key_in, root_ff, root_in;
   logic [lfu_pkg::VALUE_BITS-1:0] wval_ff, wval_in;
   logic                        func_ff, func_in;
   logic                        hit_ff, hit_in, ev_ff, ev_in, rvalid_ff, rvalid_in;
   logic [63:0]                 rd_ff, rd_in, evtag_ff, evtag_in;

   logic                        we;
   logic [lfu_pkg::IDX_W-1:0]   waddr, raddr;
   lfu_pkg::entry_type          wdata, rdata;
   logic [lfu_pkg::ENTRY_W-1:0] rdata_raw;

   lfu_ram #(.WIDTH(lfu_pkg::ENTRY_W), .DEPTH(lfu_pkg::MAX_ENTRIES)) u_heap (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata_raw)
   );
   assign rdata = lfu_pkg::entry_type'(rdata_raw);

   logic [lfu_pkg::CH_W-1:0] left_idx, right_idx, n_ext;
   logic [lfu_pkg::IDX_W-1:0] parent_idx;
   lfu_pkg::entry_type new_ent, best;
   logic [lfu_pkg::IDX_W-1:0] best_idx;
   logic best_moved;

   assign left_idx   = {1'b0, pos_ff, 1'b1};
   assign right_idx  = left_idx + lfu_pkg::CH_W'(1);
   assign n_ext      = lfu_pkg::CH_W'(total_ff);
   assign parent_idx = (pos_ff - lfu_pkg::IDX_W'(1)) >> 1;
   // capacity above the heap size acts as the heap size
   assign cap_eff = (cap_ff > lfu_pkg::CAP_W'(lfu_pkg::MAX_ENTRIES))
                    ? lfu_pkg::CAP_W'(lfu_pkg::MAX_ENTRIES) : cap_ff;

   always_comb begin
      new_ent.tag   = key_ff;
      new_ent.value = wval_ff;
      new_ent.count = 32'd1;
      new_ent.stamp = stamp_ff + 32'd1;
   end

   // sink choice among current entry and its children
   always_comb begin
      best       = cur_ff;
      best_idx   = pos_ff;
      best_moved = 1'b0;
      if (lfu_pkg::ranks_below(left_ff, best)) begin
         best       = left_ff;
         best_idx   = left_idx[lfu_pkg::IDX_W-1:0];
         best_moved = 1'b1;
      end
      if (rvld_ff && lfu_pkg::ranks_below(right_ff, best)) begin
         best       = right_ff;
         best_idx   = right_idx[lfu_pkg::IDX_W-1:0];
         best_moved = 1'b1;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {6'd0, evtag_ff, ev_ff, rd_ff, hit_ff};

   always_comb begin
      state_in = state_ff;
      cap_in   = cap_ff;
      total_in = total_ff;
      idx_in   = idx_ff;
      pos_in   = pos_ff;
      stamp_in = stamp_ff;
      cur_in   = cur_ff;
      left_in  = left_ff;
      right_in = right_ff;
      rvld_in  = rvld_ff;
      key_in   = key_ff;
      root_in  = root_ff;
      wval_in  = wval_ff;
      func_in  = func_ff;
      hit_in   = hit_ff;
      ev_in    = ev_ff;
      rd_in    = rd_ff;
      evtag_in = evtag_ff;
      rvalid_in = rvalid_ff;
      we    = 1'b0;
      waddr = pos_ff;
      wdata = cur_ff;
      raddr = idx_ff[lfu_pkg::IDX_W-1:0];

      if (csr_valid) cap_in = lfu_pkg::CAP_W'(csr_data);

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               key_in   = req_tdata[lfu_pkg::TAG_BITS-1:0];
               wval_in  = req_tdata[64 +: lfu_pkg::VALUE_BITS];
               func_in  = req_tuser[0];
               hit_in   = 1'b0;
               ev_in    = 1'b0;
               rd_in    = '0;
               evtag_in = '0;
               idx_in   = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            if (func_ff && cap_eff == '0) begin
               state_in  = S_OUT;   // disabled insert, even for a present key
               rvalid_in = 1'b1;
            end else if (idx_ff < total_ff) begin
               state_in = S_CMP;
            end else if (!func_ff) begin
               state_in  = S_OUT;   // lookup miss
               rvalid_in = 1'b1;
            end else if (lfu_pkg::CAP_W'(total_ff) >= cap_eff) begin
               ev_in    = 1'b1;
               evtag_in = 64'(root_ff);
               cur_in   = new_ent;
               stamp_in = stamp_ff + 32'd1;
               pos_in   = '0;
               state_in = S_SK;
            end else begin
               cur_in   = new_ent;
               stamp_in = stamp_ff + 32'd1;
               pos_in   = total_ff[lfu_pkg::IDX_W-1:0];
               total_in = total_ff + lfu_pkg::CNT_W'(1);
               state_in = S_SW;
            end
         end
         S_CMP: begin
            if (idx_ff == '0) root_in = rdata.tag;
            if (rdata.tag == key_ff) begin
               hit_in   = 1'b1;
               cur_in   = rdata;
               if (func_ff) cur_in.value = wval_ff;
               else rd_in = 64'(rdata.value);
               if (rdata.count != 32'hFFFF_FFFF) cur_in.count = rdata.count + 32'd1;
               cur_in.stamp = stamp_ff + 32'd1;
               stamp_in = stamp_ff + 32'd1;
               pos_in   = idx_ff[lfu_pkg::IDX_W-1:0];
               state_in = S_SK;
            end else begin
               idx_in   = idx_ff + lfu_pkg::CNT_W'(1);
               state_in = S_RD;
            end
         end
         S_SK: begin
            if (left_idx >= n_ext) begin
               we        = 1'b1;
               state_in  = S_OUT;
               rvalid_in = 1'b1;
            end else begin
               raddr    = left_idx[lfu_pkg::IDX_W-1:0];
               state_in = S_SKL;
            end
         end
         S_SKL: begin
            left_in = rdata;
            if (right_idx < n_ext) begin
               raddr    = right_idx[lfu_pkg::IDX_W-1:0];
               rvld_in  = 1'b1;
               state_in = S_SKR;
            end else begin
               rvld_in  = 1'b0;
               state_in = S_SKD;
            end
         end
         S_SKR: begin
            right_in = rdata;
            state_in = S_SKD;
         end
         S_SKD: begin
            we = 1'b1;
            if (best_moved) begin
               wdata    = best;     // child moves up, current entry goes down
               pos_in   = best_idx;
               state_in = S_SK;
            end else begin
               state_in  = S_OUT;
               rvalid_in = 1'b1;
            end
         end
         S_SW: begin
            if (pos_ff == '0) begin
               we        = 1'b1;
               state_in  = S_OUT;
               rvalid_in = 1'b1;
            end else begin
               raddr    = parent_idx;
               state_in = S_SWP;
            end
         end
         S_SWP: begin
            we = 1'b1;
            if (lfu_pkg::ranks_below(cur_ff, rdata)) begin
               wdata    = rdata;    // parent moves down
               pos_in   = parent_idx;
               state_in = S_SW;
            end else begin
               state_in  = S_OUT;
               rvalid_in = 1'b1;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               rvalid_in = 1'b0;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cap_ff    <= lfu_pkg::CAP_W'(64);
         total_ff  <= '0;
         stamp_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cap_ff    <= cap_in;
         total_ff  <= total_in;
         stamp_ff  <= stamp_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      cur_ff   <= cur_in;
      left_ff  <= left_in;
      right_ff <= right_in;
      rvld_ff  <= rvld_in;
      key_ff   <= key_in;
      root_ff  <= root_in;
      wval_ff  <= wval_in;
      func_ff  <= func_in;
      hit_ff   <= hit_in;
      ev_ff    <= ev_in;
      rd_ff    <= rd_in;
      evtag_ff <= evtag_in;
   end
endmodule
`default_nettype wire

>>> src/lfu_ram.sv
`default_nettype none
module lfu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

   // one response transaction, split into its fields
   typedef struct packed {
      logic        hit;
      logic [63:0] read_value;
      logic        evicted;
      logic [63:0] evicted_tag;
   } lfu_rsp_type;

   localparam bit OP_LOOKUP = 1'b0;
   localparam bit OP_INSERT = 1'b1;
   localparam int IDLE_LIMIT = 20000;  // far beyond scan + walk + longest stall

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;     // key_tag[63:0], write_value[127:64]
   logic [0:0]   req_tuser = '0;     // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;          // hit, read_value, evicted, evicted_tag
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [6:0]   csr_data = '0;      // capacity_in_use

   lfu_cache_heap_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------
   // Cache shadow: heap of entries, entry total, stamp, capacity
   // ---------------------------------------------------------------
   lfu_pkg::entry_type shadow_heap [lfu_pkg::MAX_ENTRIES];
   int          shadow_total = 0;
   logic [31:0] shadow_stamp = '0;
   int          shadow_cap = lfu_pkg::MAX_ENTRIES;

   lfu_rsp_type pending_rsp [$];
   int       mismatches = 0;
   int       idle_cycles = 0;
   bit       quiet_rx = 1'b0;  // stretches with the receiver always ready
   bit       quiet_tx = 1'b0;  // stretches with no sender gaps

   // a is less used than b (stamp breaks count ties)
   function automatic bit colder(lfu_pkg::entry_type a, lfu_pkg::entry_type b);
      if (a.count != b.count) return a.count < b.count;
      return a.stamp < b.stamp;
   endfunction

   function automatic void swap_entries(int a, int b);
      lfu_pkg::entry_type t;
      t = shadow_heap[a];
      shadow_heap[a] = shadow_heap[b];
      shadow_heap[b] = t;
   endfunction

   function automatic void sift_down(int pos);
      int l, r, best;
      while (pos < shadow_total) begin
         l = 2 * pos + 1;
         r = l + 1;
         best = pos;
         if (l < shadow_total && colder(shadow_heap[l], shadow_heap[best])) best = l;
         if (r < shadow_total && colder(shadow_heap[r], shadow_heap[best])) best = r;
         if (best == pos) break;
         swap_entries(best, pos);
         pos = best;
      end
   endfunction

   function automatic void sift_up(int pos);
      int p;
      while (pos > 0 && pos < shadow_total) begin
         p = (pos - 1) / 2;
         if (!colder(shadow_heap[pos], shadow_heap[p])) break;
         swap_entries(pos, p);
         pos = p;
      end
   endfunction

   function automatic void bump_entry(int slot);
      if (shadow_heap[slot].count != 32'hFFFF_FFFF)
         shadow_heap[slot].count = shadow_heap[slot].count + 1;
      shadow_stamp = shadow_stamp + 1;  // wraps at 2^32
      shadow_heap[slot].stamp = shadow_stamp;
      sift_down(slot);
   endfunction

   function automatic void fill_slot(int slot, logic [63:0] tag, logic [63:0] val);
      shadow_stamp = shadow_stamp + 1;
      shadow_heap[slot].tag   = tag;
      shadow_heap[slot].value = val;
      shadow_heap[slot].count = 32'd1;
      shadow_heap[slot].stamp = shadow_stamp;
   endfunction

   // computes the response of one request and updates the shadow
   function automatic lfu_rsp_type cache_access(bit op, logic [63:0] tag, logic [63:0] val);
      lfu_rsp_type r;
      int slot;
      int cap;
      r = '0;
      slot = -1;
      cap = (shadow_cap > lfu_pkg::MAX_ENTRIES) ? lfu_pkg::MAX_ENTRIES : shadow_cap;
      for (int i = 0; i < shadow_total; i++)
         if (slot < 0 && shadow_heap[i].tag == tag) slot = i;
      if (op == OP_LOOKUP) begin
         if (slot >= 0) begin
            r.hit = 1'b1;
            r.read_value = shadow_heap[slot].value;
            bump_entry(slot);
         end
      end else if (cap > 0) begin
         if (slot >= 0) begin
            r.hit = 1'b1;
            shadow_heap[slot].value = val;
            bump_entry(slot);
         end else if (shadow_total >= cap) begin
            // full (or over capacity after a shrink): replace the root
            r.evicted = 1'b1;
            r.evicted_tag = shadow_heap[0].tag;
            fill_slot(0, tag, val);
            sift_down(0);
         end else begin
            fill_slot(shadow_total, tag, val);
            shadow_total++;
            sift_up(shadow_total - 1);
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------
   // Driving helpers
   // ---------------------------------------------------------------
   function automatic int gap_len();
      int d;
      d = $urandom_range(0, 99);
      if (d < 60) return 0;
      if (d < 95) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // one request transaction; valid stays high across back-to-back requests
   task automatic send_req(bit op, logic [63:0] tag, logic [63:0] val);
      int g;
      lfu_rsp_type exp_rsp;
      req_tdata  = {val, tag};
      req_tuser  = op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      exp_rsp = cache_access(op, tag, val);
      pending_rsp = {pending_rsp, exp_rsp};
      @(negedge clock);
      g = quiet_tx ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid = 1'b0;
         repeat (g) @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      if (req_tvalid) begin
         req_tvalid = 1'b0;
      end
      while (pending_rsp.size() != 0) @(negedge clock);
   endtask

   // capacity write; only with nothing in flight
   task automatic set_capacity(logic [6:0] v);
      wait_drained();
      csr_data  = v;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      shadow_cap = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_basic_ops();
      send_req(OP_LOOKUP, 64'h0, 64'h0);                   // miss on empty cache
      send_req(OP_INSERT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_req(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_req(OP_LOOKUP, 64'h0, rand64());                // hit, value ignored
      send_req(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
      send_req(OP_INSERT, 64'h0, 64'hA5A5_5A5A_0F0F_F0F0); // update counts as access
      send_req(OP_LOOKUP, 64'h0, 64'h0);
      send_req(OP_LOOKUP, 64'h1234, 64'h0);                // miss
   endtask

   // small capacity: evictions pick the least used, oldest on ties
   task automatic test_evict_order();
      set_capacity(7'd3);
      send_req(OP_INSERT, 64'h10, 64'h1);
      send_req(OP_INSERT, 64'h11, 64'h2);
      send_req(OP_LOOKUP, 64'h10, 64'h0);
      send_req(OP_INSERT, 64'h12, 64'h3);
      send_req(OP_INSERT, 64'h13, 64'h4);
      send_req(OP_INSERT, 64'h14, 64'h5);
      send_req(OP_LOOKUP, 64'h10, 64'h0);
   endtask

   // shrink below the current fill, then zero, then above the maximum
   task automatic test_capacity_edges();
      set_capacity(7'd1);
      send_req(OP_INSERT, 64'h20, 64'h6);                  // evicts, surplus stays
      send_req(OP_LOOKUP, 64'h13, 64'h0);
      set_capacity(7'd0);
      send_req(OP_INSERT, 64'h20, 64'h7);                  // present key, still nothing
      send_req(OP_INSERT, 64'h30, 64'h8);
      send_req(OP_LOOKUP, 64'h20, 64'h0);                  // lookups still work
      set_capacity(7'd127);
      send_req(OP_INSERT, 64'h30, 64'h9);
      send_req(OP_LOOKUP, 64'h30, 64'h0);
   endtask

   // random traffic over a tag pool sized around the capacity
   task automatic test_random_traffic();
      logic [6:0]  caps [9] = '{7'd64, 7'd1, 7'd127, 7'd8, 7'd33, 7'd0, 7'd3, 7'd64, 7'd100};
      logic [63:0] pool [$];
      logic [63:0] tag;
      int          span;
      for (int ph = 0; ph < 9; ph++) begin
         set_capacity(caps[ph]);
         quiet_tx = (ph == 2);
         quiet_rx = (ph == 4);
         span = (caps[ph] > 64) ? 80 : int'(caps[ph]) * 3 / 2 + 2;
         pool.delete();
         for (int i = 0; i < span; i++) pool = {pool, rand64()};
         for (int k = 0; k < 210; k++) begin
            if ($urandom_range(0, 9) == 0) tag = rand64();
            else tag = pool[$urandom_range(0, span - 1)];
            send_req($urandom_range(0, 1) ? OP_INSERT : OP_LOOKUP, tag, rand64());
            if (ph == 1 && k == 100) wait_drained();  // let the pipe drain once
         end
      end
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Receiver, checker, watchdog
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (quiet_rx) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 99) < 85) ? 1'b1 : ($urandom_range(0, 19) == 0);
   end

   always @(posedge clock) begin
      lfu_rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit         = rsp_tdata[0];
         got.read_value  = rsp_tdata[64:1];
         got.evicted     = rsp_tdata[65];
         got.evicted_tag = rsp_tdata[129:66];
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %h", rsp_tdata);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: hit %b/%b rd %h/%h ev %b/%b evtag %h/%h (exp/act)",
                     want.hit, got.hit, want.read_value, got.read_value,
                     want.evicted, got.evicted, want.evicted_tag, got.evicted_tag);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic_ops();
      test_evict_order();
      test_capacity_edges();
      test_random_traffic();
      wait_drained();
      repeat (200) @(posedge clock);  // catch stray responses
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule
